FILE: rtl/mrcc_pkg.sv
// Package for the relative control-change step pulse decoder.
// Holds sizes, opcode and register codes, step constants and the saturating add.
// No dependencies.
`default_nettype none

package mrcc_pkg;

  // Channel and controller space.
  localparam int NUM_CHANNELS = 16;
  localparam int NUM_PORTS    = 8;
  localparam int STEP_BITS    = 8;
  localparam int CH_W         = 4;
  localparam int CC_COUNT     = 128;
  localparam int CC_W         = 7;
  localparam int TIMER_W      = 16;
  localparam int CFG_W        = 16;
  localparam int ACTIVE_NARROW = (NUM_PORTS < NUM_CHANNELS) ? NUM_PORTS : NUM_CHANNELS;

  localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

  // Transaction opcodes on the input channel.
  typedef enum logic [1:0] {
    OP_MIDI = 2'd0,
    OP_TICK = 2'd1,
    OP_ARM  = 2'd2
  } opcode_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PROTOCOL    = 2'd0;
  localparam logic [1:0] CFG_POLYPHONIC  = 2'd1;
  localparam logic [1:0] CFG_PULSE_TICKS = 2'd2;

  // Protocol codes.
  localparam logic [2:0] PROTO_GRADED_A = 3'd0;
  localparam logic [2:0] PROTO_BINARY_A = 3'd1;
  localparam logic [2:0] PROTO_BINARY_B = 3'd2;
  localparam logic [2:0] PROTO_GRADED_B = 3'd3;
  localparam logic [2:0] PROTO_BINARY_C = 3'd4;

  // MIDI control-change status nibble.
  localparam logic [3:0] MIDI_STATUS_CC = 4'hB;

  // Graded step thresholds.
  localparam logic [6:0] DEC_BIG_MAX   = 7'd58;
  localparam logic [6:0] DEC_MID_MAX   = 7'd61;
  localparam logic [6:0] DEC_SMALL_MAX = 7'd63;
  localparam logic [6:0] INC_BIG_MIN   = 7'd70;
  localparam logic [6:0] INC_MID_MIN   = 7'd67;
  localparam logic [6:0] INC_SMALL_MIN = 7'd65;
  localparam logic [6:0] BIN_DEC_VALUE = 7'd127;
  localparam logic [6:0] BIN_INC_VALUE = 7'd1;

  localparam logic [2:0] STEPS_BIG   = 3'd6;
  localparam logic [2:0] STEPS_MID   = 3'd4;
  localparam logic [2:0] STEPS_SMALL = 3'd2;
  localparam logic [2:0] STEPS_NONE  = 3'd0;

  localparam logic [TIMER_W-1:0] PULSE_TICKS_RESET = 16'd48;

  // Adds a small step count to a counter, saturating at the top.
  function automatic logic [STEP_BITS-1:0] sat_add(input logic [STEP_BITS-1:0] count,
                                                   input logic [2:0] n);
    logic [STEP_BITS:0] s;
    s = {1'b0, count} + {{(STEP_BITS-2){1'b0}}, n};
    return s[STEP_BITS] ? STEP_MAX : s[STEP_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/midi_relative_cc_to_step_pulses.sv
// Top level of the relative control-change step pulse decoder.
// Depends on mrcc_pkg for sizes, codes and the saturating add.
// Holds the controller-to-channel memory, per-channel counters and the output register.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_opcode..         | into block
//   result  | out_valid, out_stall, out_*_gates       | out of block
//   config  | cfg_wr_en, cfg_index, cfg_data          | into block
//
// One transaction is accepted per cycle while in_stall is low. The controller-to-channel memory
// is read when a transaction is accepted and the transaction is applied from the second-stage
// registers, where a tick's gates are loaded into the output register. Reset is synchronous
// and immediate: the mapping flags reset in flip-flops, so there is no clearing pass. A stalled
// result holds only a tick transaction in the second stage; other transactions keep flowing
// until a tick meets a full, stalled output register.
`default_nettype none

module midi_relative_cc_to_step_pulses (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_status_nibble,
  input  logic [6:0]  in_cc_number,
  input  logic [7:0]  in_cc_value,
  input  logic [3:0]  in_learn_channel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_inc_gates,
  output logic [15:0] out_dec_gates,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NCH = mrcc_pkg::NUM_CHANNELS;
  localparam int SB  = mrcc_pkg::STEP_BITS;
  localparam int TW  = mrcc_pkg::TIMER_W;
  localparam int CW  = mrcc_pkg::CC_W;
  localparam int HW  = mrcc_pkg::CH_W;

  // Configuration registers.
  logic [2:0]    cfg_protocol_r;
  logic          cfg_poly_r;
  logic [TW-1:0] cfg_pulse_ticks_r;

  // Second-stage transaction.
  logic          s1_valid_r, s1_valid_nxt;
  logic [1:0]    s1_op_r;
  logic [3:0]    s1_status_r;
  logic [CW-1:0] s1_cc_r;
  logic [7:0]    s1_value_r;
  logic [HW-1:0] s1_lch_r;

  // Controller-to-channel memory and its read-side forwarding.
  logic [HW-1:0] cc_chan_mem [mrcc_pkg::CC_COUNT];
  logic [HW-1:0] mem_rdata_r;
  logic          fwd_hit_r;
  logic [HW-1:0] fwd_data_r;
  logic          mem_we;

  // Mapping flags: mapped, and written since reset (unwritten entries map cc to the channel in its low bits).
  logic [mrcc_pkg::CC_COUNT-1:0] cc_mapped_r, cc_mapped_nxt;
  logic [mrcc_pkg::CC_COUNT-1:0] cc_written_r, cc_written_nxt;

  // Channel bindings, learn state, counters and timers.
  logic [CW-1:0] ch_cc_map_r [NCH];
  logic [HW:0]   learn_armed_r, learn_armed_nxt;
  logic [SB-1:0] inc_steps_r [NCH];
  logic [SB-1:0] inc_steps_nxt [NCH];
  logic [SB-1:0] dec_steps_r [NCH];
  logic [SB-1:0] dec_steps_nxt [NCH];
  logic [TW-1:0] inc_timer_r [NCH];
  logic [TW-1:0] inc_timer_nxt [NCH];
  logic [TW-1:0] dec_timer_r [NCH];
  logic [TW-1:0] dec_timer_nxt [NCH];

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_inc_r, out_dec_r;
  logic [15:0]   inc_gates, dec_gates;

  // Handshake and decode.
  logic          s1_fire, in_fire, s1_is_cc, s1_is_tick, s1_is_arm;
  logic          learn_do, cc_do;
  logic [HW-1:0] learn_ch;
  logic [CW-1:0] old_cc;
  logic [HW-1:0] ch_sel;
  logic [6:0]    value;
  logic [2:0]    inc_add, dec_add;

  // Stage control: a tick needs room in the output register, others always move on.
  assign s1_is_tick = (s1_op_r == mrcc_pkg::OP_TICK);
  assign s1_is_arm  = (s1_op_r == mrcc_pkg::OP_ARM);
  assign s1_is_cc   = (s1_op_r == mrcc_pkg::OP_MIDI) &&
                      (s1_status_r == mrcc_pkg::MIDI_STATUS_CC);
  assign s1_fire    = s1_valid_r && (!s1_is_tick || !out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_fire;
  assign in_fire    = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Learn and mapped-controller decode.
  assign learn_ch = learn_armed_r[HW-1:0];
  assign old_cc   = ch_cc_map_r[learn_ch];
  assign learn_do = s1_fire && s1_is_cc && learn_armed_r[HW];
  assign cc_do    = s1_fire && s1_is_cc && !learn_armed_r[HW] && cc_mapped_r[s1_cc_r];
  assign mem_we   = learn_do;
  assign ch_sel   = cc_written_r[s1_cc_r] ? (fwd_hit_r ? fwd_data_r : mem_rdata_r)
                                          : s1_cc_r[HW-1:0];

  always_comb begin
    cc_mapped_nxt   = cc_mapped_r;
    cc_written_nxt  = cc_written_r;
    learn_armed_nxt = learn_armed_r;
    if (learn_do) begin
      // The channel's old controller is unmapped first, so relearning the same one keeps it.
      cc_mapped_nxt[old_cc]   = 1'b0;
      cc_mapped_nxt[s1_cc_r]  = 1'b1;
      cc_written_nxt[s1_cc_r] = 1'b1;
      learn_armed_nxt         = '0;
    end else if (s1_fire && s1_is_arm) begin
      learn_armed_nxt = {1'b1, s1_lch_r};
    end
  end

  // Step amounts from the data byte and the protocol.
  assign value = s1_value_r[7] ? 7'd0 : s1_value_r[6:0];

  always_comb begin
    inc_add = mrcc_pkg::STEPS_NONE;
    dec_add = mrcc_pkg::STEPS_NONE;
    if (cfg_protocol_r inside {mrcc_pkg::PROTO_GRADED_A, mrcc_pkg::PROTO_GRADED_B}) begin
      if (value <= mrcc_pkg::DEC_BIG_MAX) begin
        dec_add = mrcc_pkg::STEPS_BIG;
      end else if (value <= mrcc_pkg::DEC_MID_MAX) begin
        dec_add = mrcc_pkg::STEPS_MID;
      end else if (value <= mrcc_pkg::DEC_SMALL_MAX) begin
        dec_add = mrcc_pkg::STEPS_SMALL;
      end
      if (value >= mrcc_pkg::INC_BIG_MIN) begin
        inc_add = mrcc_pkg::STEPS_BIG;
      end else if (value >= mrcc_pkg::INC_MID_MIN) begin
        inc_add = mrcc_pkg::STEPS_MID;
      end else if (value >= mrcc_pkg::INC_SMALL_MIN) begin
        inc_add = mrcc_pkg::STEPS_SMALL;
      end
    end else if (cfg_protocol_r inside {mrcc_pkg::PROTO_BINARY_A, mrcc_pkg::PROTO_BINARY_B,
                                        mrcc_pkg::PROTO_BINARY_C}) begin
      if (value == mrcc_pkg::BIN_DEC_VALUE) begin
        dec_add = mrcc_pkg::STEPS_SMALL;
      end
      if (value == mrcc_pkg::BIN_INC_VALUE) begin
        inc_add = mrcc_pkg::STEPS_SMALL;
      end
    end
  end

  // Counter and timer update: a control change touches one channel, a tick every running lane.
  always_comb begin
    inc_gates = '0;
    dec_gates = '0;
    for (int i = 0; i < NCH; i++) begin
      inc_steps_nxt[i] = inc_steps_r[i];
      dec_steps_nxt[i] = dec_steps_r[i];
      inc_timer_nxt[i] = inc_timer_r[i];
      dec_timer_nxt[i] = dec_timer_r[i];
      if (cfg_poly_r || (i < mrcc_pkg::ACTIVE_NARROW)) begin
        if (inc_timer_r[i] != '0) begin
          inc_timer_nxt[i] = inc_timer_r[i] - 1'b1;
          inc_gates[i]     = inc_steps_r[i][0];
        end else if (inc_steps_r[i] != '0) begin
          inc_timer_nxt[i] = cfg_pulse_ticks_r;
          inc_steps_nxt[i] = inc_steps_r[i] - 1'b1;
        end
        if (dec_timer_r[i] != '0) begin
          dec_timer_nxt[i] = dec_timer_r[i] - 1'b1;
          dec_gates[i]     = dec_steps_r[i][0];
        end else if (dec_steps_r[i] != '0) begin
          dec_timer_nxt[i] = cfg_pulse_ticks_r;
          dec_steps_nxt[i] = dec_steps_r[i] - 1'b1;
        end
      end
    end
    if (!(s1_fire && s1_is_tick)) begin
      for (int i = 0; i < NCH; i++) begin
        inc_steps_nxt[i] = inc_steps_r[i];
        dec_steps_nxt[i] = dec_steps_r[i];
        inc_timer_nxt[i] = inc_timer_r[i];
        dec_timer_nxt[i] = dec_timer_r[i];
      end
    end
    if (cc_do) begin
      inc_steps_nxt[ch_sel] = mrcc_pkg::sat_add(inc_steps_r[ch_sel], inc_add);
      dec_steps_nxt[ch_sel] = mrcc_pkg::sat_add(dec_steps_r[ch_sel], dec_add);
    end
  end

  // Output register: loaded by a tick, held while the far side stalls.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_fire && s1_is_tick) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_inc_gates = out_inc_r;
  assign out_dec_gates = out_dec_r;

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_protocol_r    <= '0;
      cfg_poly_r        <= 1'b0;
      cfg_pulse_ticks_r <= mrcc_pkg::PULSE_TICKS_RESET;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      learn_armed_r     <= '0;
      cc_mapped_r       <= {{(mrcc_pkg::CC_COUNT-NCH){1'b0}}, {NCH{1'b1}}};
      cc_written_r      <= '0;
      for (int i = 0; i < NCH; i++) begin
        ch_cc_map_r[i] <= CW'(i);
        inc_steps_r[i] <= '0;
        dec_steps_r[i] <= '0;
        inc_timer_r[i] <= '0;
        dec_timer_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          mrcc_pkg::CFG_PROTOCOL:    cfg_protocol_r    <= cfg_data[2:0];
          mrcc_pkg::CFG_POLYPHONIC:  cfg_poly_r        <= cfg_data[0];
          mrcc_pkg::CFG_PULSE_TICKS: cfg_pulse_ticks_r <= cfg_data;
          default: begin
          end
        endcase
      end
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      learn_armed_r <= learn_armed_nxt;
      cc_mapped_r   <= cc_mapped_nxt;
      cc_written_r  <= cc_written_nxt;
      if (learn_do) begin
        ch_cc_map_r[learn_ch] <= s1_cc_r;
      end
      for (int i = 0; i < NCH; i++) begin
        inc_steps_r[i] <= inc_steps_nxt[i];
        dec_steps_r[i] <= dec_steps_nxt[i];
        inc_timer_r[i] <= inc_timer_nxt[i];
        dec_timer_r[i] <= dec_timer_nxt[i];
      end
    end
  end

  // Payload registers of the second stage and the output.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_opcode;
      s1_status_r <= in_status_nibble;
      s1_cc_r     <= in_cc_number;
      s1_value_r  <= in_cc_value;
      s1_lch_r    <= in_learn_channel;
    end
    if (s1_fire && s1_is_tick) begin
      out_inc_r <= inc_gates;
      out_dec_r <= dec_gates;
    end
  end

  // Memory: written by a learn in the second stage, read as a transaction is accepted.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cc_chan_mem[s1_cc_r] <= learn_ch;
    end
    if (in_fire) begin
      mem_rdata_r <= cc_chan_mem[in_cc_number];
    end
  end

  // Forwarding of a write that lands on the entry being read in the same cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_hit_r  <= mem_we && (s1_cc_r == in_cc_number);
      fwd_data_r <= learn_ch;
    end
  end

endmodule

`default_nettype wire
